>>> src/ehist_pkg.sv
`timescale 1ns / 1ps
// Package for the exact histogram block: sizes, operation and sample kind codes,
// the request bundle between the top level and the bin store, and count saturation.
// Depends on nothing.
package ehist_pkg;

    localparam int BIN_COUNT     = 65536;
    localparam int BIN_IDX_W     = $clog2(BIN_COUNT);
    localparam int COUNTER_WIDTH = 32;
    localparam int OUT_COUNT_W   = 32;
    localparam int VALUE_W       = 17;
    localparam int SAMPLE_W      = 16;
    localparam int WIDE_W        = (COUNTER_WIDTH > OUT_COUNT_W) ? COUNTER_WIDTH : OUT_COUNT_W;

    localparam logic signed [VALUE_W-1:0] LEAST_RESET    = 17'sh0FFFF;
    localparam logic signed [VALUE_W-1:0] GREATEST_RESET = 17'sh18000;

    typedef enum logic [1:0] {
        OP_ACCUMULATE = 2'd0,
        OP_READ       = 2'd1,
        OP_CLEAR      = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_U8  = 2'd0,
        KIND_S8  = 2'd1,
        KIND_U16 = 2'd2,
        KIND_S16 = 2'd3
    } kind_t;

    typedef struct packed {
        logic                 valid;
        op_t                  op;
        logic [BIN_IDX_W-1:0] addr;
        logic                 in_range;
    } ehist_req_t;

    function automatic logic [OUT_COUNT_W-1:0] count_to_out(
        input logic [COUNTER_WIDTH-1:0] c
    );
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(c);
        if (wide > WIDE_W'({OUT_COUNT_W{1'b1}})) begin
            return '1;
        end
        return wide[OUT_COUNT_W-1:0];
    endfunction

endpackage

>>> src/ehist_bin_store.sv
`timescale 1ns / 1ps
// Bin store of the exact histogram: the counter memory, its read-modify-write
// stage with forwarding, and the clearing walk. Depends on ehist_pkg.
module ehist_bin_store (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ehist_pkg::ehist_req_t            req,
    input  logic                             hold,
    output logic                             busy,
    output logic                             rd_valid,
    output logic [ehist_pkg::OUT_COUNT_W-1:0] rd_count
);
    import ehist_pkg::*;

    logic [COUNTER_WIDTH-1:0] mem [BIN_COUNT];
    logic [COUNTER_WIDTH-1:0] rd_data_reg;

    logic                     s1_valid_reg, s1_valid_next;
    op_t                      s1_op_reg, s1_op_next;
    logic [BIN_IDX_W-1:0]     s1_addr_reg, s1_addr_next;
    logic                     s1_in_range_reg, s1_in_range_next;
    logic                     clear_active_reg, clear_active_next;
    logic [BIN_IDX_W-1:0]     clr_ptr_reg, clr_ptr_next;
    logic                     fwd_valid_reg, fwd_valid_next;
    logic [BIN_IDX_W-1:0]     fwd_addr_reg, fwd_addr_next;
    logic [COUNTER_WIDTH-1:0] fwd_data_reg, fwd_data_next;

    logic                     wr_en;
    logic [BIN_IDX_W-1:0]     wr_addr;
    logic [COUNTER_WIDTH-1:0] wr_data;
    logic [COUNTER_WIDTH-1:0] cur_count;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid && !hold) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    always_comb begin
        cur_count = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data_reg;
        wr_en     = 1'b0;
        wr_addr   = s1_addr_reg;
        wr_data   = cur_count;
        if (clear_active_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_reg;
            wr_data = '0;
        end else if (s1_valid_reg && (s1_op_reg == OP_ACCUMULATE) && s1_in_range_reg) begin
            wr_en = 1'b1;
            if (cur_count != '1) begin
                wr_data = cur_count + COUNTER_WIDTH'(1);
            end
        end
    end

    assign rd_valid = s1_valid_reg && (s1_op_reg == OP_READ);
    assign rd_count = s1_in_range_reg ? count_to_out(cur_count) : '0;
    assign busy     = clear_active_reg || (s1_valid_reg && (s1_op_reg == OP_CLEAR));

    always_comb begin
        s1_valid_next     = s1_valid_reg;
        s1_op_next        = s1_op_reg;
        s1_addr_next      = s1_addr_reg;
        s1_in_range_next  = s1_in_range_reg;
        fwd_valid_next    = fwd_valid_reg;
        fwd_addr_next     = fwd_addr_reg;
        fwd_data_next     = fwd_data_reg;
        clear_active_next = clear_active_reg;
        clr_ptr_next      = clr_ptr_reg;

        if (!hold) begin
            s1_valid_next    = req.valid;
            s1_op_next       = req.op;
            s1_addr_next     = req.addr;
            s1_in_range_next = req.in_range;
            fwd_valid_next   = wr_en;
            fwd_addr_next    = wr_addr;
            fwd_data_next    = wr_data;
        end

        if (clear_active_reg) begin
            clr_ptr_next = clr_ptr_reg + BIN_IDX_W'(1);
            if (clr_ptr_reg == BIN_IDX_W'(BIN_COUNT - 1)) begin
                clear_active_next = 1'b0;
            end
        end else if (s1_valid_reg && (s1_op_reg == OP_CLEAR)) begin
            clear_active_next = 1'b1;
            clr_ptr_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            clear_active_reg <= 1'b1;
            clr_ptr_reg      <= '0;
        end else begin
            s1_valid_reg     <= s1_valid_next;
            fwd_valid_reg    <= fwd_valid_next;
            clear_active_reg <= clear_active_next;
            clr_ptr_reg      <= clr_ptr_next;
        end
        s1_op_reg       <= s1_op_next;
        s1_addr_reg     <= s1_addr_next;
        s1_in_range_reg <= s1_in_range_next;
        fwd_addr_reg    <= fwd_addr_next;
        fwd_data_reg    <= fwd_data_next;
    end

endmodule

>>> src/exact_histogram_min_max.sv
`timescale 1ns / 1ps
// Top level of the exact histogram with running minimum and maximum.
// Depends on ehist_pkg and ehist_bin_store.
//
// Accumulate and read items are taken one per cycle while the block is not
// busy and no read is held: each bin is read from a counter memory with one
// read and one write port, incremented and written back, with forwarding when
// consecutive items hit the same bin. A read result passes the store's stage
// register and then the result register. A read whose result cannot leave
// because the result register is still full holds the input until the result
// register is free. A clear item holds the input while the store is walked
// one bin per cycle, and the same walk runs after reset before the first item
// is accepted. The sample kind may be written at any time the block is idle.
module exact_histogram_min_max (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,    // sample_kind
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // sample_bits [15:0], bin_index [31:16]
    input  logic [1:0]  s_tuser,     // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata      // bin_count [31:0], least_value [48:32],
                                     // greatest_value [65:49], nothing_seen [66]
);
    import ehist_pkg::*;

    kind_t                      kind_reg, kind_next;
    logic signed [VALUE_W-1:0]  least_reg, least_next;
    logic signed [VALUE_W-1:0]  greatest_reg, greatest_next;
    logic                       seen_reg, seen_next;
    logic                       out_valid_reg, out_valid_next;
    logic [OUT_COUNT_W-1:0]     out_count_reg, out_count_next;
    logic signed [VALUE_W-1:0]  out_least_reg, out_least_next;
    logic signed [VALUE_W-1:0]  out_greatest_reg, out_greatest_next;
    logic                       out_empty_reg, out_empty_next;

    logic                       accept;
    logic                       stall;
    logic                       busy;
    logic                       rd_valid;
    logic [OUT_COUNT_W-1:0]     rd_count;
    op_t                        op;
    logic [SAMPLE_W-1:0]        sample;
    logic [SAMPLE_W-1:0]        read_index;
    logic signed [VALUE_W-1:0]  value;
    logic [SAMPLE_W-1:0]        sample_index;
    logic [SAMPLE_W-1:0]        index;
    ehist_req_t                 req;

    assign op         = op_t'(s_tuser);
    assign sample     = s_tdata[15:0];
    assign read_index = s_tdata[31:16];

    assign stall    = rd_valid && out_valid_reg && !m_tready;
    assign s_tready = !busy && !stall;
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        case (kind_reg)
            KIND_U8: begin
                value        = VALUE_W'({1'b0, sample[7:0]});
                sample_index = SAMPLE_W'(sample[7:0]);
            end
            KIND_S8: begin
                value        = VALUE_W'(signed'(sample[7:0]));
                sample_index = SAMPLE_W'({~sample[7], sample[6:0]});
            end
            KIND_U16: begin
                value        = {1'b0, sample};
                sample_index = sample;
            end
            default: begin
                value        = {sample[15], sample};
                sample_index = {~sample[15], sample[14:0]};
            end
        endcase
    end

    always_comb begin
        index        = (op == OP_READ) ? read_index : sample_index;
        req.valid    = accept;
        req.op       = op;
        req.addr     = index[BIN_IDX_W-1:0];
        req.in_range = ({1'b0, index} < (SAMPLE_W + 1)'(BIN_COUNT));
    end

    ehist_bin_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .hold     (stall),
        .busy     (busy),
        .rd_valid (rd_valid),
        .rd_count (rd_count)
    );

    always_comb begin
        kind_next     = kind_reg;
        least_next    = least_reg;
        greatest_next = greatest_reg;
        seen_next     = seen_reg;
        if (cfg_valid && cfg_ready) begin
            kind_next = kind_t'(cfg_data);
        end
        if (accept) begin
            case (op)
                OP_ACCUMULATE: begin
                    if (value < least_reg) begin
                        least_next = value;
                    end
                    if (value > greatest_reg) begin
                        greatest_next = value;
                    end
                    seen_next = 1'b1;
                end
                OP_CLEAR: begin
                    least_next    = LEAST_RESET;
                    greatest_next = GREATEST_RESET;
                    seen_next     = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next    = out_valid_reg;
        out_count_next    = out_count_reg;
        out_least_next    = out_least_reg;
        out_greatest_next = out_greatest_reg;
        out_empty_next    = out_empty_reg;
        if (rd_valid && !stall) begin
            out_valid_next    = 1'b1;
            out_count_next    = rd_count;
            out_least_next    = least_reg;
            out_greatest_next = greatest_reg;
            out_empty_next    = !seen_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= KIND_U8;
            least_reg     <= LEAST_RESET;
            greatest_reg  <= GREATEST_RESET;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            kind_reg      <= kind_next;
            least_reg     <= least_next;
            greatest_reg  <= greatest_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
        out_count_reg    <= out_count_next;
        out_least_reg    <= out_least_next;
        out_greatest_reg <= out_greatest_next;
        out_empty_reg    <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_empty_reg, out_greatest_reg, out_least_reg, out_count_reg};

endmodule

>>> tb/exact_histogram_min_max_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the exact histogram block: it watches the configuration, input and result
// channels, keeps its own histogram, extremes and sample kind, and compares every read result.
// Depends on ehist_pkg.
module exact_histogram_min_max_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          mismatches,
    output int          reports_due
);
    import ehist_pkg::*;

    typedef struct {
        logic [31:0]               count;
        logic signed [VALUE_W-1:0] least;
        logic signed [VALUE_W-1:0] greatest;
        logic                      empty;
    } bin_report_t;

    bin_report_t               awaited[$];
    logic [31:0]               tally[int];
    kind_t                     kind;
    logic signed [VALUE_W-1:0] low_mark;
    logic signed [VALUE_W-1:0] high_mark;
    logic                      seen_any;

    function automatic void check_field(input string name, input logic signed [40:0] want,
                                        input logic signed [40:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        bin_report_t               got;
        bin_report_t               want;
        logic [15:0]               raw;
        logic [15:0]               slot;
        logic signed [VALUE_W-1:0] value;
        if (!aresetn) begin
            tally.delete();
            awaited.delete();
            kind      = KIND_U8;
            low_mark  = LEAST_RESET;
            high_mark = GREATEST_RESET;
            seen_any  = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.count    = m_tdata[31:0];
                got.least    = m_tdata[48:32];
                got.greatest = m_tdata[65:49];
                got.empty    = m_tdata[66];
                if (awaited.size() == 0) begin
                    $error("result item arrived with no read outstanding");
                    mismatches++;
                end else begin
                    want = awaited.pop_front();
                    check_field("bin_count", want.count, got.count);
                    check_field("least_value", want.least, got.least);
                    check_field("greatest_value", want.greatest, got.greatest);
                    check_field("nothing_seen", want.empty, got.empty);
                end
            end
            if (s_tvalid && s_tready) begin
                raw  = s_tdata[15:0];
                slot = s_tdata[31:16];
                case (s_tuser)
                    OP_ACCUMULATE: begin
                        case (kind)
                            KIND_U8: begin
                                value = {9'd0, raw[7:0]};
                                slot  = {8'd0, raw[7:0]};
                            end
                            KIND_S8: begin
                                value = {{9{raw[7]}}, raw[7:0]};
                                slot  = {8'd0, ~raw[7], raw[6:0]};
                            end
                            KIND_U16: begin
                                value = {1'b0, raw};
                                slot  = raw;
                            end
                            default: begin
                                value = {raw[15], raw};
                                slot  = {~raw[15], raw[14:0]};
                            end
                        endcase
                        if (value < low_mark) begin
                            low_mark = value;
                        end
                        if (value > high_mark) begin
                            high_mark = value;
                        end
                        seen_any = 1'b1;
                        if (!tally.exists(slot)) begin
                            tally[slot] = '0;
                        end
                        if (tally[slot] != '1) begin
                            tally[slot] = tally[slot] + 1;
                        end
                    end
                    OP_READ: begin
                        want.count    = tally.exists(slot) ? tally[slot] : '0;
                        want.least    = low_mark;
                        want.greatest = high_mark;
                        want.empty    = !seen_any;
                        awaited.push_back(want);
                    end
                    OP_CLEAR: begin
                        tally.delete();
                        low_mark  = LEAST_RESET;
                        high_mark = GREATEST_RESET;
                        seen_any  = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (cfg_valid && cfg_ready) begin
                kind = kind_t'(cfg_data);
            end
        end
        reports_due <= awaited.size();
    end

endmodule

>>> tb/exact_histogram_min_max_test.sv
`timescale 1ns / 1ps
// Testbench top for the exact histogram block: clock, reset, stimulus and the verdict.
// Depends on ehist_pkg, exact_histogram_min_max and exact_histogram_min_max_checker.
module exact_histogram_min_max_test;
    import ehist_pkg::*;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [63:0] EDGE_SAMPLES = 64'hFFFF_8000_7FFF_0000;
    localparam int          PHASE_ITEMS  = 150;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;

    int mismatches;
    int reports_due;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    int clears_left = 4;
    bit clear_in_flight = 1'b0;

    exact_histogram_min_max u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    exact_histogram_min_max_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // A long hold, once requested, is counted down here rather than in the sender.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [15:0] slot_of(input kind_t k, input logic [15:0] s);
        case (k)
            KIND_U8:  return {8'd0, s[7:0]};
            KIND_S8:  return {8'd0, s[7:0] ^ 8'h80};
            KIND_U16: return s;
            default:  return s ^ 16'h8000;
        endcase
    endfunction

    task automatic offer_item(input logic [1:0] op, input logic [15:0] sample,
                              input logic [15:0] slot);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {slot, sample};
        do @(posedge aclk); while (!s_tready);
        clear_in_flight = (op == OP_CLEAR);
    endtask

    // A clear gives no result, so after one the walk over the store is waited out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reports_due != 0) @(posedge aclk);
        repeat (clear_in_flight ? BIN_COUNT + 8 : 8) @(posedge aclk);
        clear_in_flight = 1'b0;
    endtask

    task automatic set_kind(input kind_t k);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input kind_t k, input int gap, input int stall,
                             input bit squeeze);
        logic [15:0] hot[3];
        logic [15:0] sample;
        logic [15:0] slot;
        int          counted;
        int          accs;
        int          reads;
        int          pick;
        bit          squeezed;
        set_kind(k);
        gap_pct   = gap;
        stall_pct = stall;
        counted   = 0;
        squeezed  = 1'b0;
        foreach (hot[j]) hot[j] = 16'($urandom);
        while (counted < PHASE_ITEMS) begin
            if (squeeze && !squeezed && counted >= PHASE_ITEMS / 2) begin
                hold_left = 400;
                repeat (24) offer_item(OP_READ, 16'($urandom), slot_of(k, hot[0]));
                drain();
                counted += 24;
                squeezed = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 78) begin
                foreach (hot[j]) begin
                    hot[j] = ($urandom_range(9) == 0) ?
                             EDGE_SAMPLES[16 * $urandom_range(3) +: 16] : 16'($urandom);
                end
                accs = $urandom_range(1, 10);
                repeat (accs) begin
                    sample = ($urandom_range(4) == 0) ? 16'($urandom) : hot[$urandom_range(2)];
                    offer_item(OP_ACCUMULATE, sample, 16'($urandom));
                end
                reads = $urandom_range(1, 3);
                repeat (reads) begin
                    slot = ($urandom_range(9) == 0) ? 16'($urandom) :
                           slot_of(k, hot[$urandom_range(2)]);
                    offer_item(OP_READ, 16'($urandom), slot);
                end
                counted += accs + reads;
            end else if (pick < 97 || clears_left == 0) begin
                pick = $urandom_range(2);
                offer_item(pick == 0 ? OP_ACCUMULATE : pick == 1 ? OP_READ : OP_UNUSED,
                           16'($urandom), 16'($urandom));
                if (pick != 2) begin
                    counted++;
                end
            end else begin
                clears_left--;
                offer_item(OP_CLEAR, 16'($urandom), 16'($urandom));
                offer_item(OP_READ, 16'($urandom), slot_of(k, hot[0]));
                counted += 2;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // An empty histogram straight after reset, in the reset kind.
        offer_item(OP_READ, 16'($urandom), 16'h0000);

        set_kind(KIND_S16);
        offer_item(OP_ACCUMULATE, 16'h8000, 16'($urandom));
        offer_item(OP_ACCUMULATE, 16'h7FFF, 16'($urandom));
        offer_item(OP_ACCUMULATE, 16'h0000, 16'($urandom));
        repeat (3) offer_item(OP_ACCUMULATE, 16'hFFFF, 16'($urandom));
        offer_item(OP_READ, 16'($urandom), 16'h0000);
        offer_item(OP_READ, 16'($urandom), 16'hFFFF);
        offer_item(OP_READ, 16'($urandom), 16'h8000);
        offer_item(OP_READ, 16'($urandom), 16'h7FFF);
        offer_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        offer_item(OP_READ, 16'($urandom), 16'h7FFF);

        // The kind changes without a clear, so new samples land on top of the old ones.
        set_kind(KIND_U8);
        offer_item(OP_ACCUMULATE, 16'hABFF, 16'($urandom));
        offer_item(OP_ACCUMULATE, 16'h5400, 16'($urandom));
        offer_item(OP_READ, 16'($urandom), 16'h00FF);
        offer_item(OP_READ, 16'($urandom), 16'h0000);
        offer_item(OP_CLEAR, 16'($urandom), 16'($urandom));
        offer_item(OP_READ, 16'($urandom), 16'h00FF);
        offer_item(OP_ACCUMULATE, 16'h0080, 16'($urandom));
        offer_item(OP_READ, 16'($urandom), 16'h0080);

        set_kind(KIND_S8);
        offer_item(OP_ACCUMULATE, 16'h0080, 16'($urandom));
        offer_item(OP_ACCUMULATE, 16'h007F, 16'($urandom));
        offer_item(OP_READ, 16'($urandom), 16'h0000);
        offer_item(OP_READ, 16'($urandom), 16'h00FF);

        run_phase(KIND_U16, 0, 0, 1'b1);
        run_phase(KIND_S8, 48, 0, 1'b0);
        run_phase(KIND_U8, 0, 48, 1'b0);
        run_phase(KIND_S16, 21, 21, 1'b0);

        drain();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && reports_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> exact_histogram_min_max.f
src/ehist_pkg.sv
src/ehist_bin_store.sv
src/exact_histogram_min_max.sv
tb/exact_histogram_min_max_checker.sv
tb/exact_histogram_min_max_test.sv
